>>> design/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked on every rising edge outside reset
`define ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked on every rising edge outside reset
`define ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/dcfc_pkg.sv
`default_nettype none

package dcfc_pkg;

    // frame class codes
    typedef logic [1:0] class_t;

    localparam class_t CLASS_CCITT_OK  = 2'd0;
    localparam class_t CLASS_MODBUS_OK = 2'd1;
    localparam class_t CLASS_UNCONF    = 2'd2;
    localparam class_t CLASS_SHORT     = 2'd3;

    // byte counter saturates at the minimum frame length
    localparam int unsigned CNT_W = 3;
    localparam logic [CNT_W-1:0] MIN_FRAME_BYTES = 3'd4;

    // word handed from the front part to the queue
    typedef struct packed {
        logic   push;
        class_t cls;
    } push_word_t;

    // queue status seen by the front and back parts
    typedef struct packed {
        logic empty;
        logic full;
    } q_status_t;

endpackage

`default_nettype wire

>>> design/dcfc_front.sv
`default_nettype none

module dcfc_front
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    input  wire logic [7:0]            data_byte,
    input  wire logic                  end_of_frame,
    input  wire dcfc_pkg::q_status_t   q_status,
    output logic                       in_stall,
    output dcfc_pkg::push_word_t       push_word
);

    localparam logic [15:0] MODBUS_SEED = 16'hFFFF;
    localparam logic [15:0] MODBUS_POLY = 16'hA001;
    localparam logic [15:0] CCITT_SEED  = 16'h0000;
    localparam logic [15:0] CCITT_POLY  = 16'h1021;
    localparam logic [dcfc_pkg::CNT_W-1:0] HOLD_BYTES = 3'd2;

    // reflected byte-wide crc update
    function automatic logic [15:0] modbus_update(input logic [15:0] crc_in,
                                                  input logic [7:0]  b);
        logic [15:0] c;
        c = crc_in ^ {8'h00, b};
        for (int k = 0; k < 8; k++)
        begin
            if (c[0])
                c = (c >> 1) ^ MODBUS_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

    // msb-first byte-wide crc update
    function automatic logic [15:0] ccitt_update(input logic [15:0] crc_in,
                                                 input logic [7:0]  b);
        logic [15:0] c;
        c = crc_in ^ {b, 8'h00};
        for (int k = 0; k < 8; k++)
        begin
            if (c[15])
                c = (c << 1) ^ CCITT_POLY;
            else
                c = c << 1;
        end
        return c;
    endfunction

    logic [15:0]                 modbus_crc_reg, modbus_crc_next;
    logic [15:0]                 ccitt_crc_reg, ccitt_crc_next;
    logic [7:0]                  older_byte_reg, older_byte_next;
    logic [7:0]                  newer_byte_reg, newer_byte_next;
    logic [dcfc_pkg::CNT_W-1:0]  bytes_seen_reg, bytes_seen_next;
    logic                        accept;
    logic [15:0]                 modbus_upd;
    logic [15:0]                 ccitt_upd;
    logic [dcfc_pkg::CNT_W-1:0]  bytes_upd;
    dcfc_pkg::class_t            cls;

    // stall whenever the queue cannot take a word
    assign in_stall = q_status.full;
    assign accept   = in_valid && !q_status.full;

    // crcs advance over the byte leaving the two-byte delay line
    always_comb
    begin
        if (bytes_seen_reg >= HOLD_BYTES)
        begin
            modbus_upd = modbus_update(modbus_crc_reg, older_byte_reg);
            ccitt_upd  = ccitt_update(ccitt_crc_reg, older_byte_reg);
        end
        else
        begin
            modbus_upd = modbus_crc_reg;
            ccitt_upd  = ccitt_crc_reg;
        end
        if (bytes_seen_reg < dcfc_pkg::MIN_FRAME_BYTES)
            bytes_upd = bytes_seen_reg + 3'd1;
        else
            bytes_upd = bytes_seen_reg;
    end

    // classify against the trailer: the newer delay-line byte and the current data_byte
    always_comb
    begin
        priority if (bytes_upd < dcfc_pkg::MIN_FRAME_BYTES)
            cls = dcfc_pkg::CLASS_SHORT;
        else if (modbus_upd == {data_byte, newer_byte_reg})
            cls = dcfc_pkg::CLASS_MODBUS_OK;
        else if (ccitt_upd == {newer_byte_reg, data_byte})
            cls = dcfc_pkg::CLASS_CCITT_OK;
        else
            cls = dcfc_pkg::CLASS_UNCONF;
    end

    // next state: frame end returns everything to its reset value
    always_comb
    begin
        modbus_crc_next = modbus_crc_reg;
        ccitt_crc_next  = ccitt_crc_reg;
        older_byte_next = older_byte_reg;
        newer_byte_next = newer_byte_reg;
        bytes_seen_next = bytes_seen_reg;
        if (accept)
        begin
            if (end_of_frame)
            begin
                modbus_crc_next = MODBUS_SEED;
                ccitt_crc_next  = CCITT_SEED;
                older_byte_next = 8'h00;
                newer_byte_next = 8'h00;
                bytes_seen_next = '0;
            end
            else
            begin
                modbus_crc_next = modbus_upd;
                ccitt_crc_next  = ccitt_upd;
                older_byte_next = newer_byte_reg;
                newer_byte_next = data_byte;
                bytes_seen_next = bytes_upd;
            end
        end
    end

    assign push_word.push = accept && end_of_frame;
    assign push_word.cls  = cls;

    // frame state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modbus_crc_reg <= MODBUS_SEED;
            ccitt_crc_reg  <= CCITT_SEED;
            older_byte_reg <= 8'h00;
            newer_byte_reg <= 8'h00;
            bytes_seen_reg <= '0;
        end
        else
        begin
            modbus_crc_reg <= modbus_crc_next;
            ccitt_crc_reg  <= ccitt_crc_next;
            older_byte_reg <= older_byte_next;
            newer_byte_reg <= newer_byte_next;
            bytes_seen_reg <= bytes_seen_next;
        end
    end

endmodule

`default_nettype wire

>>> design/dcfc_queue.sv
`default_nettype none

module dcfc_queue
#(
    parameter int unsigned DEPTH = 2
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire dcfc_pkg::push_word_t  push_word,
    input  wire logic                  pop,
    output dcfc_pkg::class_t           head_cls,
    output dcfc_pkg::q_status_t        q_status
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    dcfc_pkg::class_t  entry_reg [DEPTH];
    logic [AW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]     count_reg, count_next;
    logic              do_push;
    logic              do_pop;

    assign q_status.empty = (count_reg == '0);
    assign q_status.full  = (count_reg == FULL_CNT);
    assign head_cls       = entry_reg[rd_ptr_reg];

    assign do_push = push_word.push && !q_status.full;
    assign do_pop  = pop && !q_status.empty;

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        unique case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_word.cls;
    end

endmodule

`default_nettype wire

>>> design/dcfc_back.sv
`default_nettype none

module dcfc_back
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire dcfc_pkg::q_status_t  q_status,
    input  wire dcfc_pkg::class_t     head_cls,
    input  wire logic                 out_stall,
    output logic                      pop,
    output logic                      out_valid,
    output dcfc_pkg::class_t          frame_class
);

    logic              out_valid_reg, out_valid_next;
    dcfc_pkg::class_t  frame_class_reg;

    // refill the output register when it is empty or being taken
    assign pop = !q_status.empty && (!out_valid_reg || !out_stall);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (pop)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    // output word
    always_ff @(posedge clk)
    begin
        if (pop)
            frame_class_reg <= head_cls;
    end

    assign out_valid   = out_valid_reg;
    assign frame_class = frame_class_reg;

endmodule

`default_nettype wire

>>> design/dual_crc16_frame_classifier.sv
// a frame's class enters the class queue at the edge that accepts its final byte
// and then moves into the output register once that register is free or being taken
// throughput: one byte per cycle while not stalled, including back-to-back one-byte frames
// a 2-entry class queue lets the byte side run on while the output is stalled
// input stalls only when that queue is full
// reset (rst_n low, async) restores crc seeds, empties the queue and drops out_valid
`default_nettype none

module dual_crc16_frame_classifier
#(
    parameter int unsigned QUEUE_DEPTH = 2
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  data_byte,
    input  wire logic        end_of_frame,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [1:0]       frame_class
);

    dcfc_pkg::push_word_t  push_word;
    dcfc_pkg::q_status_t   q_status;
    dcfc_pkg::class_t      head_cls;
    logic                  pop;

    // byte intake, crc tracking and classification
    dcfc_front u_front
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .data_byte    (data_byte),
        .end_of_frame (end_of_frame),
        .q_status     (q_status),
        .in_stall     (in_stall),
        .push_word    (push_word)
    );

    // class words waiting for the output side
    dcfc_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_word (push_word),
        .pop       (pop),
        .head_cls  (head_cls),
        .q_status  (q_status)
    );

    // output register
    dcfc_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_status    (q_status),
        .head_cls    (head_cls),
        .out_stall   (out_stall),
        .pop         (pop),
        .out_valid   (out_valid),
        .frame_class (frame_class)
    );

endmodule

`default_nettype wire

>>> design/dcfc_checker.sv
`default_nettype none
`include "assert_macros.svh"

module dcfc_checker
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    input  wire logic        in_stall,
    input  wire logic [7:0]  data_byte,
    input  wire logic        end_of_frame,
    input  wire logic        out_valid,
    input  wire logic        out_stall,
    input  wire logic [1:0]  frame_class
);

    logic out_hold;
    logic out_take;
    logic in_busy;

    assign out_hold = out_valid && out_stall;
    assign out_take = out_valid && !out_stall;
    assign in_busy  = in_valid && in_stall && (data_byte == data_byte) && !end_of_frame;

    // a stalled output word holds
    `ASSERT_NXT(a_out_hold, clk, rst_n, out_hold, out_valid && $stable(frame_class), "output word changed while stalled")

    // with nothing on the output the queue cannot be full
    `ASSERT_IMP(a_no_stall_idle, clk, rst_n, !out_valid, !in_stall, "input stalled with empty output")

    // input stall only clears after an output word leaves
    `ASSERT_IMP(a_stall_release, clk, rst_n, $fell(in_stall), $past(out_take), "stall cleared without output drain")

    // a stalled mid-frame byte means a word is waiting on the output
    `ASSERT_IMP(a_busy_out, clk, rst_n, in_busy, out_valid, "input stalled without pending output")

endmodule

bind dual_crc16_frame_classifier dcfc_checker u_dcfc_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .data_byte    (data_byte),
    .end_of_frame (end_of_frame),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .frame_class  (frame_class)
);

`default_nettype wire

>>> dv/tb_dual_crc16_frame_classifier.sv
`timescale 1ns / 100ps

// one byte through the reflected modbus crc, polynomial 0xA001
function automatic logic [15:0] modbus_next(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++)
        c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
    return c;
endfunction

// one byte through the msb-first xmodem crc, polynomial 0x1021
function automatic logic [15:0] xmodem_next(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++)
        c = c[15] ? ((c << 1) ^ 16'h1021) : (c << 1);
    return c;
endfunction

class frame_class_scoreboard;
    dcfc_pkg::class_t expected_classes[$];
    int               mismatches;

    // running state of the classifier as seen from the byte side
    logic [15:0] mod_crc;
    logic [15:0] cc_crc;
    logic [7:0]  older;
    logic [7:0]  newer;
    logic [2:0]  seen;

    function void restart();
        mod_crc = 16'hFFFF;
        cc_crc  = 16'h0000;
        older   = 8'h00;
        newer   = 8'h00;
        seen    = 3'd0;
    endfunction

    // accepted byte: advance the crcs and predict the class on frame end
    function void note_byte(input logic [7:0] b, input logic eof);
        dcfc_pkg::class_t cls;
        logic [15:0]      mod_want;
        logic [15:0]      cc_want;
        if (seen >= 3'd2)
        begin
            mod_crc = modbus_next(mod_crc, older);
            cc_crc  = xmodem_next(cc_crc, older);
        end
        older = newer;
        newer = b;
        if (seen < dcfc_pkg::MIN_FRAME_BYTES)
            seen = seen + 3'd1;
        if (eof)
        begin
            if (seen < dcfc_pkg::MIN_FRAME_BYTES)
                cls = dcfc_pkg::CLASS_SHORT;
            else
            begin
                mod_want = {newer, older};
                cc_want  = {older, newer};
                if (mod_crc == mod_want)
                    cls = dcfc_pkg::CLASS_MODBUS_OK;
                else if (cc_crc == cc_want)
                    cls = dcfc_pkg::CLASS_CCITT_OK;
                else
                    cls = dcfc_pkg::CLASS_UNCONF;
            end
            expected_classes.push_back(cls);
            restart();
        end
    endfunction

    // accepted result word against the oldest prediction
    function void check_class(input dcfc_pkg::class_t got);
        dcfc_pkg::class_t want;
        if (expected_classes.size() == 0)
        begin
            $display("%0t: frame_class %0d with no frame pending", $time, got);
            mismatches++;
        end
        else
        begin
            want = expected_classes.pop_front();
            if (got !== want)
            begin
                $display("%0t: frame_class expected %0d actual %0d", $time, want, got);
                mismatches++;
            end
        end
    endfunction

    function int pending();
        return expected_classes.size();
    endfunction
endclass

module tb_dual_crc16_frame_classifier;

    typedef enum {FRAME_MODBUS, FRAME_CCITT, FRAME_CORRUPT, FRAME_NOISE, FRAME_SHORT} frame_kind_t;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_stall;
    logic [7:0]        data_byte;
    logic              end_of_frame;
    logic              out_valid;
    logic              out_stall;
    dcfc_pkg::class_t  frame_class;

    frame_class_scoreboard sb;
    logic [7:0]  frame_buf[$];
    int          bytes_sent;
    logic        quiet;
    logic        gaps_on;

    dual_crc16_frame_classifier u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .data_byte    (data_byte),
        .end_of_frame (end_of_frame),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .frame_class  (frame_class)
    );

    // clock
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // run limit
    initial
    begin
        #5_000_000;
        $display("[dual_crc16_frame_classifier] ERROR");
        $finish;
    end

    // result side
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_class(frame_class);
    end

    // receiver stall bursts, none in the quiet tail
    initial
    begin
        int run;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            run = ($urandom_range(0, 5) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 30);
            repeat (run) @(negedge clk) out_stall <= 1'b0;
            if (!quiet && $urandom_range(0, 3) != 0)
                repeat ($urandom_range(1, 19)) @(negedge clk) out_stall <= 1'b1;
        end
    end

    // present one word and hold it until accepted; called at a falling edge
    task automatic send_byte(input logic [7:0] b, input logic eof);
        in_valid     <= 1'b1;
        data_byte    <= b;
        end_of_frame <= eof;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_byte(b, eof);
        bytes_sent++;
        @(negedge clk);
    endtask

    // sender idle for a gap whose length n sets, payload scrambled meanwhile
    task automatic idle_gap(input int n);
        in_valid     <= 1'b0;
        data_byte    <= 8'($urandom);
        end_of_frame <= 1'($urandom);
        repeat (n) @(negedge clk);
    endtask

    // hold the sender until every frame class has come back
    task automatic drain_results();
        in_valid <= 1'b0;
        @(negedge clk);
        while (sb.pending() != 0)
            @(negedge clk);
    endtask

    // append the two trailer bytes that the frame kind calls for; short frames get none
    task automatic add_trailer(input frame_kind_t kind);
        logic [15:0] m;
        logic [15:0] x;
        int          pos;
        m = 16'hFFFF;
        x = 16'h0000;
        foreach (frame_buf[i])
        begin
            m = modbus_next(m, frame_buf[i]);
            x = xmodem_next(x, frame_buf[i]);
        end
        case (kind)
            FRAME_MODBUS:
            begin
                frame_buf.push_back(m[7:0]);
                frame_buf.push_back(m[15:8]);
            end
            FRAME_CCITT:
            begin
                frame_buf.push_back(x[15:8]);
                frame_buf.push_back(x[7:0]);
            end
            FRAME_CORRUPT:
            begin
                frame_buf.push_back(m[7:0]);
                frame_buf.push_back(m[15:8]);
                pos = $urandom_range(0, frame_buf.size() - 1);
                frame_buf[pos] = frame_buf[pos] ^ (8'h01 << $urandom_range(0, 7));
            end
            FRAME_NOISE:
            begin
                frame_buf.push_back(8'($urandom));
                frame_buf.push_back(8'($urandom));
            end
            default:
            begin
            end
        endcase
    endtask

    // send frame_buf with the end mark on its last word
    task automatic send_frame_buf();
        foreach (frame_buf[i])
        begin
            if (!quiet && gaps_on && $urandom_range(0, 7) == 0)
                idle_gap($urandom_range(1, 19));
            send_byte(frame_buf[i], i == frame_buf.size() - 1);
        end
    endtask

    // three-byte payload whose xmodem crc is the byte-swapped modbus crc
    task automatic find_dual_payload(output logic hit, output logic [7:0] p0,
                                     output logic [7:0] p1, output logic [7:0] p2);
        logic [15:0] m2;
        logic [15:0] x2;
        logic [15:0] m3;
        logic [15:0] x3;
        hit = 1'b0;
        p0 = 8'h00;
        p1 = 8'h00;
        p2 = 8'h00;
        for (int i = 0; i < 256 && !hit; i++)
            for (int j = 0; j < 256 && !hit; j++)
            begin
                m2 = modbus_next(modbus_next(16'hFFFF, 8'(i)), 8'(j));
                x2 = xmodem_next(xmodem_next(16'h0000, 8'(i)), 8'(j));
                for (int k = 0; k < 256 && !hit; k++)
                begin
                    m3 = modbus_next(m2, 8'(k));
                    x3 = xmodem_next(x2, 8'(k));
                    if (x3 == {m3[7:0], m3[15:8]})
                    begin
                        hit = 1'b1;
                        p0 = 8'(i);
                        p1 = 8'(j);
                        p2 = 8'(k);
                    end
                end
            end
    endtask

    // stimulus
    initial
    begin
        frame_kind_t kind;
        int          pick;
        int          plen;
        int          frames;
        logic        hit;
        logic [7:0]  p0;
        logic [7:0]  p1;
        logic [7:0]  p2;

        sb = new;
        sb.restart();
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        data_byte    = 8'h00;
        end_of_frame = 1'b0;
        bytes_sent   = 0;
        quiet        = 1'b0;
        gaps_on      = 1'b1;
        find_dual_payload(hit, p0, p1, p2);
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // one-byte frame, shortest possible
        frame_buf = {8'h00};
        send_frame_buf();
        // three-byte frame, one short of the minimum
        frame_buf = {8'hFF, 8'h80, 8'h01};
        send_frame_buf();
        // minimum length frames with a good modbus and a good xmodem trailer
        frame_buf = {8'h00, 8'h00};
        add_trailer(FRAME_MODBUS);
        send_frame_buf();
        frame_buf = {8'hFF, 8'hFF};
        add_trailer(FRAME_CCITT);
        send_frame_buf();
        // both crcs agree with the trailer, modbus takes priority
        frame_buf = {p0, p1, p2};
        add_trailer(FRAME_MODBUS);
        send_frame_buf();
        // neither crc matches
        frame_buf = {8'h5A, 8'hA5, 8'h3C, 8'hC3};
        send_frame_buf();

        drain_results();

        // random frames, mostly well formed
        frames = 0;
        while (bytes_sent < 1250)
        begin
            if (bytes_sent > 1100)
                quiet = 1'b1;
            if (frames % 8 == 0)
                gaps_on = ($urandom_range(0, 2) != 0);
            pick = $urandom_range(0, 99);
            kind = (pick < 40) ? FRAME_MODBUS :
                   (pick < 70) ? FRAME_CCITT :
                   (pick < 80) ? FRAME_CORRUPT :
                   (pick < 90) ? FRAME_NOISE : FRAME_SHORT;
            pick = $urandom_range(0, 99);
            plen = (pick < 5) ? $urandom_range(0, 1) :
                   (pick < 85) ? $urandom_range(2, 10) : $urandom_range(11, 40);
            if (kind == FRAME_SHORT)
                plen = $urandom_range(1, 3);
            frame_buf = {};
            repeat (plen) frame_buf.push_back(8'($urandom));
            add_trailer(kind);
            send_frame_buf();
            frames++;
            if (!quiet && $urandom_range(0, 39) == 0)
                drain_results();
        end

        // let the last results come back
        in_valid <= 1'b0;
        @(negedge clk);
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);
        if (sb.pending() != 0)
            $display("%0t: %0d frame classes never arrived", $time, sb.pending());
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("[dual_crc16_frame_classifier] OK");
        else
            $display("[dual_crc16_frame_classifier] ERROR");
        $finish;
    end
endmodule
